// ----- hdl/tpsd_pkg.sv -----
// Shared types and constants for the TGA pixel stream decoder.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package tpsd_pkg;

   // Command queue between byte front end and pixel back end
   localparam int TPSD_QUEUE_DEPTH = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FOUR_BYTE_PIXELS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RLE_MODE         = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIRROR_X         = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_TO_BOTTOM    = 3'd5;

   localparam logic [15:0] RESET_IMAGE_WIDTH  = 16'd1;
   localparam logic [15:0] RESET_IMAGE_HEIGHT = 16'd1;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;

   // Alpha for 24-bit pixels
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        four_byte_pixels;
      logic        rle_mode;
      logic        mirror_x;
      logic        top_to_bottom;
   } cfg_type;

   // One decoded pixel value and how many times it is written
   typedef struct packed {
      logic       restart;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] count;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_MUL,
      BK_ADD,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

// ----- hdl/tpsd_front.sv -----
// Byte front end: assembles BGR(A) pixels and parses run-length packet headers.
// Pushes one pixel command per completed pixel. Depends on tpsd_pkg.
`default_nettype none

module tpsd_front import tpsd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       byte_valid,
   input  wire logic [7:0] byte_data,
   input  wire logic       byte_first,
   output logic            byte_ready,
   input  wire logic       queue_full,
   output logic            cmd_push,
   output cmd_type         cmd
);

   logic [7:0]  left_ff, left_in;
   logic        raw_ff, raw_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] pix_ff, pix_in;
   logic        pend_ff, pend_in;

   logic        take;
   logic [7:0]  left_cur;
   logic        raw_cur;
   logic [1:0]  phase_cur;
   logic [23:0] pix_cur;
   logic [1:0]  last_phase;

   assign byte_ready = ~queue_full;
   assign take       = byte_valid & ~queue_full;

   // A restart word sees cleared decode state
   assign left_cur   = byte_first ? 8'd0  : left_ff;
   assign raw_cur    = byte_first ? 1'b0  : raw_ff;
   assign phase_cur  = byte_first ? 2'd0  : phase_ff;
   assign pix_cur    = byte_first ? 24'd0 : pix_ff;
   assign last_phase = cfg.four_byte_pixels ? 2'd3 : 2'd2;

   // Decode one word
   always_comb begin
      left_in  = left_ff;
      raw_in   = raw_ff;
      phase_in = phase_ff;
      pix_in   = pix_ff;
      pend_in  = pend_ff;
      cmd_push = 1'b0;
      cmd      = '0;
      if (take) begin
         left_in  = left_cur;
         raw_in   = raw_cur;
         phase_in = phase_cur;
         pix_in   = pix_cur;
         pend_in  = pend_ff | byte_first;
         if (cfg.rle_mode && (left_cur == 8'd0)) begin
            // packet header: count in low bits, top bit set for a run
            left_in  = {1'b0, byte_data[6:0]} + 8'd1;
            raw_in   = ~byte_data[7];
            phase_in = 2'd0;
         end else if (phase_cur < last_phase) begin
            case (phase_cur)
               2'd0:    pix_in[7:0]   = byte_data;
               2'd1:    pix_in[15:8]  = byte_data;
               default: pix_in[23:16] = byte_data;
            endcase
            phase_in = phase_cur + 2'd1;
         end else begin
            // final byte of a pixel
            phase_in    = 2'd0;
            cmd_push    = 1'b1;
            cmd.restart = pend_ff | byte_first;
            pend_in     = 1'b0;
            cmd.blue    = pix_cur[7:0];
            cmd.green   = pix_cur[15:8];
            cmd.red     = cfg.four_byte_pixels ? pix_cur[23:16] : byte_data;
            cmd.alpha   = cfg.four_byte_pixels ? byte_data : ALPHA_OPAQUE;
            cmd.count   = 8'd1;
            if (cfg.rle_mode) begin
               if (raw_cur) begin
                  left_in = left_cur - 8'd1;
               end else begin
                  cmd.count = left_cur;
                  left_in   = 8'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         raw_ff   <= 1'b0;
         phase_ff <= '0;
         pix_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         left_ff  <= left_in;
         raw_ff   <= raw_in;
         phase_ff <= phase_in;
         pix_ff   <= pix_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tpsd_queue.sv -----
// Short command queue between front end and back end, register based.
// Depends on tpsd_pkg for the command type.
`default_nettype none

module tpsd_queue import tpsd_pkg::*; #(
   parameter int DEPTH = TPSD_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_cmd,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tpsd_back.sv -----
// Pixel back end: walks the bitmap position, computes addresses and packs
// pixel pairs into the output register. Depends on tpsd_pkg.
`default_nettype none

module tpsd_back import tpsd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  cmd_valid,
   input  wire cmd_type               cmd,
   output logic                       cmd_pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [RSP_DATA_W-1:0]      out_data,
   output logic [RSP_USER_W-1:0]      out_user,
   output logic                       out_last
);

   back_state_type state_ff, state_in;

   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic        done_ff, done_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        slot_ff, slot_in;
   logic        sec_ff, sec_in;
   logic [31:0] color_ff, color_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] x_ff, x_in;
   logic [31:0] addr0_ff, addr0_in;
   logic [31:0] addr1_ff, addr1_in;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_W-1:0] out_user_ff, out_user_in;
   logic                  out_last_ff, out_last_in;

   logic        col_wrap;
   logic [16:0] row_inc;
   logic [16:0] col_inc;
   logic [15:0] chk_col;
   logic [15:0] chk_row;
   logic        chk_done;
   logic        chk_ok;
   logic [15:0] x_pos;
   logic [15:0] y_pos;
   logic [31:0] prod_mul;
   logic [31:0] addr_sum;
   logic        out_free;
   logic        last_res;

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_user  = out_user_ff;
   assign out_last  = out_last_ff;

   assign cmd_pop  = (state_ff == BK_IDLE) & cmd_valid;
   assign out_free = ~out_valid_ff | out_ready;
   assign last_res = (cnt_ff == 8'd0) | done_ff;

   assign col_wrap = (col_ff >= cfg.image_width);
   assign row_inc  = {1'b0, row_ff} + 17'd1;
   assign col_inc  = {1'b0, col_ff} + 17'd1;

   // Position check: brings column and row into range, flags end of image
   always_comb begin
      chk_col  = col_ff;
      chk_row  = row_ff;
      chk_done = done_ff;
      chk_ok   = 1'b0;
      if (done_ff) begin
         chk_ok = 1'b0;
      end else if (cfg.image_width == 16'd0) begin
         chk_done = 1'b1;
      end else begin
         if (col_wrap) begin
            chk_col = 16'd0;
            chk_row = row_inc[15:0];
         end
         if (col_wrap && row_inc[16]) begin
            chk_done = 1'b1;
         end else if (chk_row >= cfg.image_height) begin
            chk_done = 1'b1;
         end else begin
            chk_ok = 1'b1;
         end
      end
   end

   // Bitmap coordinates; 16x16 product, registered before the add
   assign x_pos    = cfg.mirror_x ? (cfg.image_width - 16'd1 - col_ff) : col_ff;
   assign y_pos    = cfg.top_to_bottom ? row_ff : (cfg.image_height - 16'd1 - row_ff);
   assign prod_mul = {16'd0, y_pos} * {16'd0, cfg.image_width};
   assign addr_sum = prod_ff + {16'd0, x_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (chk_ok) begin
               state_in = BK_MUL;
            end else if (slot_ff) begin
               state_in = BK_OUT;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_MUL: begin
            state_in = BK_ADD;
         end
         BK_ADD: begin
            if (!slot_ff && (cnt_ff != 8'd0)) begin
               state_in = BK_CHECK;
            end else begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = last_res ? BK_IDLE : BK_CHECK;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Datapath and output register
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      sec_in       = sec_ff;
      color_in     = color_ff;
      prod_in      = prod_ff;
      x_in         = x_ff;
      addr0_in     = addr0_ff;
      addr1_in     = addr1_ff;
      out_valid_in = out_valid_ff & ~out_ready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               color_in = {cmd.alpha, cmd.blue, cmd.green, cmd.red};
               cnt_in   = cmd.count;
               slot_in  = 1'b0;
               sec_in   = 1'b0;
               if (cmd.restart) begin
                  col_in  = 16'd0;
                  row_in  = 16'd0;
                  done_in = 1'b0;
               end
            end
         end
         BK_CHECK: begin
            col_in  = chk_col;
            row_in  = chk_row;
            done_in = chk_done;
         end
         BK_MUL: begin
            prod_in = prod_mul;
            x_in    = x_pos;
            cnt_in  = cnt_ff - 8'd1;
            // step to the next stream position
            if (col_inc >= {1'b0, cfg.image_width}) begin
               col_in = 16'd0;
               row_in = row_inc[15:0];
               if (row_inc[16] || (row_inc >= {1'b0, cfg.image_height})) begin
                  done_in = 1'b1;
               end
            end else begin
               col_in = col_inc[15:0];
            end
         end
         BK_ADD: begin
            if (slot_ff) begin
               addr1_in = addr_sum;
               sec_in   = 1'b1;
            end else begin
               addr0_in = addr_sum;
               if (cnt_ff != 8'd0) begin
                  slot_in = 1'b1;
               end
            end
         end
         BK_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {color_ff, (sec_ff ? addr1_ff : 32'd0), addr0_ff};
               out_user_in  = {done_ff, sec_ff};
               out_last_in  = last_res;
               slot_in      = 1'b0;
               sec_in       = 1'b0;
            end
         end
         default: begin
            slot_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         cnt_ff       <= '0;
         slot_ff      <= 1'b0;
         sec_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         sec_ff       <= sec_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      addr0_ff    <= addr0_in;
      addr1_ff    <= addr1_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

// ----- hdl/tga_pixel_stream_decoder.sv -----
// Path: a word that completes a pixel is pushed into the command queue; the back end
// pops it in BK_IDLE and runs BK_CHECK, BK_MUL and BK_ADD for each pixel of a result word,
// then loads the output register in BK_OUT, waiting there while the result channel stalls.
// Throughput: one word per cycle while the command queue has room; one command at a time.
// Reset: synchronous, active high; clears all control state, registers to defaults.
// Top level: configuration registers, front end, command queue, back end.
`default_nettype none

module tga_pixel_stream_decoder import tpsd_pkg::*; #(
   parameter int QUEUE_DEPTH = TPSD_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input words
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] first_of_image
   // results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // addr_first, addr_second,
                                                   // red, green, blue, alpha
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // second_valid, image_done
   output logic                       rsp_tlast,   // last
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    queue_full;
   logic    queue_empty;
   logic    cmd_push;
   logic    cmd_pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:      cfg_in.image_width      = csr_wdata;
            CSR_IMAGE_HEIGHT:     cfg_in.image_height     = csr_wdata;
            CSR_FOUR_BYTE_PIXELS: cfg_in.four_byte_pixels = csr_wdata[0];
            CSR_RLE_MODE:         cfg_in.rle_mode         = csr_wdata[0];
            CSR_MIRROR_X:         cfg_in.mirror_x         = csr_wdata[0];
            CSR_TOP_TO_BOTTOM:    cfg_in.top_to_bottom    = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= RESET_IMAGE_WIDTH;
         cfg_ff.image_height     <= RESET_IMAGE_HEIGHT;
         cfg_ff.four_byte_pixels <= 1'b0;
         cfg_ff.rle_mode         <= 1'b0;
         cfg_ff.mirror_x         <= 1'b0;
         cfg_ff.top_to_bottom    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_first (req_tuser),
      .byte_ready (req_tready),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   tpsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (cmd_pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   tpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (~queue_empty),
      .cmd       (pop_cmd),
      .cmd_pop   (cmd_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- hdl/tpsd_checker.sv -----
// Port-level checks for the TGA pixel stream decoder, bound to the top level.
// Depends on tpsd_pkg for port widths.
`default_nettype none

module tpsd_checker import tpsd_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Single-pixel words carry a zero second address
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[63:32] == 32'd0)
      else $error("second address set without second pixel");

   // Only the closing word of a byte can carry a single pixel
   a_pair_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[0])
      else $error("inner word of a run carries one pixel");

   // The final pixel of an image closes the byte's results
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("image done without last");

   // Nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind tga_pixel_stream_decoder tpsd_checker u_tpsd_checker (.*);

`default_nettype wire

// ----- bench/tga_pixel_stream_decoder_checker.sv -----
// Scoreboard for the TGA pixel stream decoder: shadows the CSRs, predicts every
// result word from the accepted input bytes and compares the result channel.
// Depends on tpsd_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module tga_pixel_stream_decoder_checker import tpsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] first_of_image
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // addr_first, addr_second,
                                              // red, green, blue, alpha
   input  logic [RSP_USER_W-1:0] rsp_tuser,   // second_valid, image_done
   input  logic                  rsp_tlast,   // last
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           pending,
   output int unsigned           checked_count
);

   typedef struct packed {
      logic [31:0] addr_first;
      logic [31:0] addr_second;
      logic        second_valid;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last;
      logic        image_done;
   } pixel_word_type;

   pixel_word_type expected_pixels[$];

   // Shadow registers and decoder position
   cfg_type     cfg_shadow;
   int unsigned col_pos;
   int unsigned row_pos;
   int unsigned run_left;
   bit          run_is_literal;
   int unsigned byte_idx;
   logic [23:0] color_bytes;
   bit          image_over;

   task automatic restart_image();
      col_pos        = 0;
      row_pos        = 0;
      run_left       = 0;
      run_is_literal = 0;
      byte_idx       = 0;
      color_bytes    = '0;
      image_over     = 0;
   endtask

   // Wraps the position into the image; 0 once no pixel is left
   function automatic bit pos_in_image();
      if (image_over)
         return 1'b0;
      if (cfg_shadow.image_width == 16'd0) begin
         image_over = 1;
         return 1'b0;
      end
      if (col_pos >= cfg_shadow.image_width) begin
         col_pos = 0;
         row_pos = (row_pos + 1) & 32'hFFFF;
         if (row_pos == 0) begin
            image_over = 1;
            return 1'b0;
         end
      end
      if (row_pos >= cfg_shadow.image_height) begin
         image_over = 1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [31:0] bitmap_addr();
      logic [31:0] w, h, x, y;
      w = {16'h0, cfg_shadow.image_width};
      h = {16'h0, cfg_shadow.image_height};
      x = cfg_shadow.mirror_x ? (w - 32'd1 - col_pos) : col_pos;
      y = cfg_shadow.top_to_bottom ? row_pos : (h - 32'd1 - row_pos);
      return y * w + x;
   endfunction

   task automatic step_pixel();
      col_pos++;
      if (col_pos >= cfg_shadow.image_width) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= cfg_shadow.image_height || row_pos > 32'hFFFF)
            image_over = 1;
      end
   endtask

   // Pixels go out in pairs; the last word of the batch carries tlast
   task automatic emit_pixels(input int unsigned count, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a);
      pixel_word_type cur;
      pixel_word_type held;
      bit             have_held;
      have_held = 0;
      held      = '0;
      while (count > 0 && pos_in_image()) begin
         if (have_held)
            expected_pixels.push_back(held);
         cur = '0;
         cur.addr_first = bitmap_addr();
         step_pixel();
         count--;
         if (count > 0 && pos_in_image()) begin
            cur.addr_second  = bitmap_addr();
            cur.second_valid = 1'b1;
            step_pixel();
            count--;
         end
         cur.red        = r;
         cur.green      = g;
         cur.blue       = b;
         cur.alpha      = a;
         cur.image_done = image_over;
         held      = cur;
         have_held = 1;
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_pixels.push_back(held);
      end
   endtask

   task automatic decode_byte(input logic [7:0] data, input logic first);
      int unsigned need;
      int unsigned count;
      logic [7:0]  r, a;
      if (first)
         restart_image();
      if (image_over)
         return;
      // packet header
      if (cfg_shadow.rle_mode && run_left == 0) begin
         run_left       = data[6:0] + 1;
         run_is_literal = !data[7];
         byte_idx       = 0;
         return;
      end
      need = cfg_shadow.four_byte_pixels ? 4 : 3;
      if (byte_idx + 1 < need) begin
         color_bytes[8*byte_idx +: 8] = data;
         byte_idx++;
         return;
      end
      if (need == 4) begin
         r = color_bytes[23:16];
         a = data;
      end else begin
         r = data;
         a = ALPHA_OPAQUE;
      end
      byte_idx = 0;
      count    = 1;
      if (cfg_shadow.rle_mode) begin
         if (run_is_literal) begin
            run_left--;
         end else begin
            count    = run_left;
            run_left = 0;
         end
      end
      emit_pixels(count, r, color_bytes[15:8], color_bytes[7:0], a);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      pixel_word_type want;
      pixel_word_type got;
      if (reset) begin
         cfg_shadow                  = '0;
         cfg_shadow.image_width      = RESET_IMAGE_WIDTH;
         cfg_shadow.image_height     = RESET_IMAGE_HEIGHT;
         restart_image();
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               CSR_IMAGE_WIDTH:      cfg_shadow.image_width      = csr_wdata;
               CSR_IMAGE_HEIGHT:     cfg_shadow.image_height     = csr_wdata;
               CSR_FOUR_BYTE_PIXELS: cfg_shadow.four_byte_pixels = csr_wdata[0];
               CSR_RLE_MODE:         cfg_shadow.rle_mode         = csr_wdata[0];
               CSR_MIRROR_X:         cfg_shadow.mirror_x         = csr_wdata[0];
               CSR_TOP_TO_BOTTOM:    cfg_shadow.top_to_bottom    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata[7:0], req_tuser);
         // result compare
         if (rsp_tvalid && rsp_tready) begin
            got.addr_first   = rsp_tdata[31:0];
            got.addr_second  = rsp_tdata[63:32];
            got.red          = rsp_tdata[71:64];
            got.green        = rsp_tdata[79:72];
            got.blue         = rsp_tdata[87:80];
            got.alpha        = rsp_tdata[95:88];
            got.second_valid = rsp_tuser[0];
            got.image_done   = rsp_tuser[1];
            got.last         = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected none actual %h %h %h",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_pixels.pop_front();
               checked_count++;
               check_field("addr_first",   want.addr_first,   got.addr_first);
               check_field("addr_second",  want.addr_second,  got.addr_second);
               check_field("second_valid", want.second_valid, got.second_valid);
               check_field("red",          want.red,          got.red);
               check_field("green",        want.green,        got.green);
               check_field("blue",         want.blue,         got.blue);
               check_field("alpha",        want.alpha,        got.alpha);
               check_field("last",         want.last,         got.last);
               check_field("image_done",   want.image_done,   got.image_done);
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ----- bench/tga_pixel_stream_decoder_tb.sv -----
// Top of the TGA pixel stream decoder bench: clock, reset, byte stimulus,
// result back-pressure and the verdict. Depends on tpsd_pkg, the block and the checker.
`timescale 1ns / 1ps

module tga_pixel_stream_decoder_tb import tpsd_pkg::*;;

   localparam int DRAIN_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned checked_count;

   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 45;
   int unsigned words_sent    = 0;
   int unsigned images_run    = 0;

   // byte stream of the image being built
   logic [7:0] img_bytes[$];
   bit         img_first[$];

   always #5 clock = ~clock;

   tga_pixel_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tga_pixel_stream_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // Result back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one byte, with a random gap in front, and wait for acceptance
   task automatic send_word(input logic [7:0] data, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   // Stop sending until every expected word is back and the block has settled
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_all(input cfg_type c);
      write_reg(CSR_IMAGE_WIDTH,      c.image_width);
      write_reg(CSR_IMAGE_HEIGHT,     c.image_height);
      write_reg(CSR_FOUR_BYTE_PIXELS, {15'd0, c.four_byte_pixels});
      write_reg(CSR_RLE_MODE,         {15'd0, c.rle_mode});
      write_reg(CSR_MIRROR_X,         {15'd0, c.mirror_x});
      write_reg(CSR_TOP_TO_BOTTOM,    {15'd0, c.top_to_bottom});
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type make_cfg(input logic [15:0] w, input logic [15:0] h,
                                        input bit four, input bit rle,
                                        input bit mx, input bit ttb);
      cfg_type c;
      c.image_width      = w;
      c.image_height     = h;
      c.four_byte_pixels = four;
      c.rle_mode         = rle;
      c.mirror_x         = mx;
      c.top_to_bottom    = ttb;
      return c;
   endfunction

   // Mostly tiny images, now and then empty or huge
   function automatic logic [15:0] rand_dim();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3)
         return 16'd0;
      if (r < 8)
         return 16'hFFFF;
      return 16'($urandom_range(1, 5));
   endfunction

   function automatic cfg_type rand_cfg();
      return make_cfg(rand_dim(), rand_dim(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   task automatic push_byte(input logic [7:0] data, input bit first);
      img_first.push_back(first || img_bytes.size() == 0);
      img_bytes.push_back(data);
   endtask

   task automatic push_pixels(input int unsigned n, input int unsigned need);
      repeat (n * need) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // One random image: noise, or a well-formed stream that may be paused
   // part way and continued under new register values
   task automatic random_image();
      cfg_type     c;
      int unsigned need, left, cnt, target, style, cut, k;
      bit          is_run;
      logic [7:0]  hdr;
      c = rand_cfg();
      wait_drained();
      write_all(c);
      images_run++;
      img_bytes.delete();
      img_first.delete();
      need  = c.four_byte_pixels ? 4 : 3;
      style = $urandom_range(99);
      if (style < 12) begin
         repeat ($urandom_range(8, 24))
            push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
         if (c.image_width > 8 || c.image_height > 8)
            target = $urandom_range(1, 12);
         else
            target = c.image_width * c.image_height;
         if (target == 0)
            target = 1;
         left = target;
         while (left > 0) begin
            if (!c.rle_mode) begin
               push_pixels(1, need);
               left--;
            end else begin
               is_run = 1'($urandom_range(1));
               if (is_run && $urandom_range(9) == 0)
                  cnt = $urandom_range(1, 128);
               else
                  cnt = $urandom_range(1, (left < 8) ? left : 8);
               hdr    = 8'(cnt - 1);
               hdr[7] = is_run;
               push_byte(hdr, 1'b0);
               push_pixels(is_run ? 1 : cnt, need);
               left = (cnt >= left) ? 0 : left - cnt;
            end
         end
         // trailing bytes past the end of the image
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
      end
      cut = img_bytes.size();
      if (style >= 12 && style < 30 && img_bytes.size() > 1)
         cut = $urandom_range(1, img_bytes.size() - 1);
      for (k = 0; k < img_bytes.size(); k++) begin
         if (k == cut) begin
            wait_drained();
            if (style < 22)
               write_all(rand_cfg());
         end
         send_word(img_bytes[k], img_first[k]);
      end
   endtask

   initial begin
      int unsigned ph, start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 1x1 after reset, extreme byte values, then one byte past the image
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'hA5, 1'b0);

      // longest run (128 pixels, 64 words), then a literal packet, 32-bit pixels
      wait_drained();
      write_all(make_cfg(16'd16, 16'd16, 1'b1, 1'b1, 1'b1, 1'b1));
      send_word(8'hFF, 1'b1);
      send_word(8'h12, 1'b0);
      send_word(8'h34, 1'b0);
      send_word(8'h56, 1'b0);
      send_word(8'h78, 1'b0);
      send_word(8'h01, 1'b0);
      repeat (8) send_word(8'($urandom_range(255)), 1'b0);

      // mid-image: narrower width, leave rle and 32-bit mode
      wait_drained();
      write_all(make_cfg(16'd1, 16'd16, 1'b0, 1'b0, 1'b1, 1'b1));
      repeat (3) send_word(8'($urandom_range(255)), 1'b0);

      // largest image, mirrored, bottom first: highest address
      wait_drained();
      write_all(make_cfg(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
      send_word(8'hC3, 1'b1);
      send_word(8'h3C, 1'b0);
      send_word(8'h81, 1'b0);

      // empty image
      wait_drained();
      write_all(make_cfg(16'd0, 16'd4, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(8'h11, 1'b1);
      send_word(8'h22, 1'b0);
      send_word(8'h33, 1'b0);

      // run longer than the rest of the image
      wait_drained();
      write_all(make_cfg(16'd2, 16'd2, 1'b0, 1'b1, 1'b0, 1'b1));
      send_word(8'h85, 1'b1);
      send_word(8'h44, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'h66, 1'b0);

      // random images under three pacing schemes
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 21; recv_idle_pct = 45; end
            1: begin send_idle_pct = 45; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         start = words_sent;
         while (words_sent - start < 35)
            random_image();
      end

      wait_drained();
      $display("Covered %0d input words over %0d random images plus directed cases;",
               words_sent, images_run);
      $display("%0d result words compared under three handshake pacing schemes.",
               checked_count);
      if (fail_count == 0)
         $display("tga_pixel_stream_decoder test passed");
      else
         $display("tga_pixel_stream_decoder test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("tga_pixel_stream_decoder test failed");
      $finish;
   end

endmodule

// ----- tga_pixel_stream_decoder.f -----
hdl/tpsd_pkg.sv
hdl/tpsd_front.sv
hdl/tpsd_queue.sv
hdl/tpsd_back.sv
hdl/tga_pixel_stream_decoder.sv
hdl/tpsd_checker.sv
bench/tga_pixel_stream_decoder_checker.sv
bench/tga_pixel_stream_decoder_tb.sv
